@@ rtl/core/ade_pkg.sv @@
// ade_pkg: action, error and control types shared by the deque engine.
// No dependencies.
package ade_pkg;

  typedef enum logic [3:0] {
    ACT_ADD_REAR  = 4'd0,
    ACT_ADD_FRONT = 4'd1,
    ACT_POP_FRONT = 4'd2,
    ACT_POP_REAR  = 4'd3,
    ACT_PEEK_FRONT = 4'd4,
    ACT_PEEK_REAR = 4'd5,
    ACT_MEMBER    = 4'd6,
    ACT_REPLACE   = 4'd7,
    ACT_CLEAR     = 4'd8,
    ACT_REVERSE   = 4'd9,
    ACT_GET       = 4'd10,
    ACT_REMOVE    = 4'd11,
    ACT_INSERT    = 4'd12,
    ACT_SORT      = 4'd13,
    ACT_NOP14     = 4'd14,
    ACT_NOP15     = 4'd15
  } action_t;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_FULL  = 3'd1;
  localparam logic [2:0] ERR_EMPTY = 3'd2;
  localparam logic [2:0] ERR_POS   = 3'd3;
  localparam logic [2:0] ERR_SHIFT = 3'd4;

  // Datapath walk operations
  typedef enum logic [2:0] {
    WALK_DOWN  = 3'd0, // store[a] <= store[a+1], a++ (remove)
    WALK_UP    = 3'd1, // store[a+1] <= store[a], a-- (make room)
    WALK_SWAP  = 3'd2, // swap a and b, a++, b--   (reverse)
    WALK_CMP   = 3'd3, // compare-swap a, a+1, a++ (sort pass)
    WALK_SCAN  = 3'd4, // compare a with value, a++ (member)
    WALK_COPY  = 3'd5  // store[a] <= store[b], a++, b++ until b hits DEPTH (compact)
  } walk_t;

  typedef struct packed {
    logic       start;
    walk_t      op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

@@ rtl/core/ade_if.sv @@
// ade_if: valid/ready channel carrying a request or a result beat.
// Depends on nothing.
interface ade_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] value;
  logic [4:0] position;
  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface ade_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       found;
  logic [2:0] error_code;
  logic [4:0] entry_count;
  logic       is_full;
  logic       vacant;
  logic [4:0] front_place;
  logic [4:0] rear_place;
  modport source (output valid, read_data, found, error_code, entry_count, is_full,
                  vacant, front_place, rear_place, input ready);
  modport sink   (input valid, read_data, found, error_code, entry_count, is_full,
                  vacant, front_place, rear_place, output ready);
endinterface

@@ rtl/core/ade_store.sv @@
// ade_store: entry store and walker that moves, swaps, compares entries.
// Depends on ade_pkg.
module ade_store import ade_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  input  logic signed [IW-1:0] a_init,
  input  logic signed [IW-1:0] b_init,
  input  logic [7:0]           value,
  input  logic                 wr_en,
  input  logic signed [IW-1:0] wr_addr,
  input  logic [7:0]           wr_data,
  input  logic signed [IW-1:0] rd_addr,
  output logic [7:0]           rd_data,
  output logic                 hit,
  output logic                 swapped,
  output dp_sts_t              sts
);
  localparam int AW = $clog2(DEPTH);

  logic [7:0] store [DEPTH];
  logic signed [IW-1:0] a, b;
  logic busy;
  walk_t op;

  function automatic logic [AW-1:0] ix(input logic signed [IW-1:0] i);
    return i[AW-1:0];
  endfunction

  function automatic logic inr(input logic signed [IW-1:0] i);
    return (i >= 0) && (i < IW'(DEPTH));
  endfunction

  assign sts.busy = busy;

  // a small store: every slot is a register; the walk touches at most two per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      hit <= 1'b0;
      swapped <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      op <= cmd.op;
      a <= a_init;
      b <= b_init;
      hit <= 1'b0;
      swapped <= 1'b0;
    end else if (busy) begin
      case (op)
        WALK_DOWN: begin
          if (a < b) begin
            if (inr(a) && inr(a + 2'sd1)) store[ix(a)] <= store[ix(a + 2'sd1)];
            a <= a + 2'sd1;
          end else busy <= 1'b0;
        end
        WALK_UP: begin
          if (a >= b) begin
            if (inr(a) && inr(a + 2'sd1)) store[ix(a + 2'sd1)] <= store[ix(a)];
            a <= a - 2'sd1;
          end else busy <= 1'b0;
        end
        WALK_SWAP: begin
          if (a < b) begin
            if (inr(a) && inr(b)) begin
              store[ix(a)] <= store[ix(b)];
              store[ix(b)] <= store[ix(a)];
            end
            a <= a + 2'sd1;
            b <= b - 2'sd1;
          end else busy <= 1'b0;
        end
        WALK_CMP: begin
          if (a < b) begin
            if (inr(a) && inr(a + 2'sd1) && store[ix(a)] > store[ix(a + 2'sd1)]) begin
              store[ix(a)] <= store[ix(a + 2'sd1)];
              store[ix(a + 2'sd1)] <= store[ix(a)];
              swapped <= 1'b1;
            end
            a <= a + 2'sd1;
          end else busy <= 1'b0;
        end
        WALK_SCAN: begin
          if (a <= b && !hit) begin
            if (inr(a) && store[ix(a)] == value) hit <= 1'b1;
            a <= a + 2'sd1;
          end else busy <= 1'b0;
        end
        WALK_COPY: begin
          if (b < IW'(DEPTH)) begin
            if (inr(a) && inr(b)) store[ix(a)] <= store[ix(b)];
            a <= a + 2'sd1;
            b <= b + 2'sd1;
          end else busy <= 1'b0;
        end
        default: busy <= 1'b0;
      endcase
    end else if (wr_en && inr(wr_addr)) begin
      store[ix(wr_addr)] <= wr_data;
    end
  end

  assign rd_data = inr(rd_addr) ? store[ix(rd_addr)] : 8'd0;

  ap_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !busy) else $error("walk started while busy");
  ap_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> busy) else $error("walk did not start");
  ap_no_wr_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en) else $error("write during walk");
endmodule

@@ rtl/core/ade_ctrl.sv @@
// ade_ctrl: controller state machine and index registers of the deque.
// Depends on ade_pkg and ade_if; drives the walk commands of ade_store.
module ade_ctrl import ade_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  ade_req_if.sink               req,
  ade_rsp_if.source             rsp,
  output dp_cmd_t               cmd,
  output logic signed [IW-1:0]  a_init,
  output logic signed [IW-1:0]  b_init,
  output logic [7:0]            value,
  output logic                  wr_en,
  output logic signed [IW-1:0]  wr_addr,
  output logic [7:0]            wr_data,
  output logic signed [IW-1:0]  rd_addr,
  input  logic [7:0]            rd_data,
  input  logic                  hit,
  input  logic                  swapped,
  input  dp_sts_t               sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_WAIT = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam logic signed [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic signed [IW-1:0] NEG1 = -1;

  state_t state, state_next;
  logic signed [IW-1:0] front, rear;
  action_t act;
  logic [7:0] val;
  logic signed [IW-1:0] pos;
  logic signed [IW-1:0] n;
  logic signed [IW-1:0] pass;    // sort passes remaining
  logic sorting;

  logic empty, full;
  assign empty = (front == rear);
  assign full  = (rear == LAST);
  assign n = (empty || rear < front) ? '0 : rear - front;
  assign value = val;

  // a launched walk shows start for one cycle before busy rises
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid) state_next = S_WALK;
      S_WALK: state_next = S_WAIT;
      S_WAIT: if (!sts.busy && !cmd.start)
        state_next = (sorting && pass > 1 && swapped) ? S_WAIT : S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT:  if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);

  // S_WALK: check errors, launch walk if needed. S_WAIT: walk in progress.
  // S_FIN: final write and index update, result latched.
  always_ff @(posedge clk) begin
    cmd.start <= 1'b0;
    wr_en <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      front <= NEG1;
      rear <= NEG1;
      sorting <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (req.valid) begin
          act <= action_t'(req.action);
          val <= req.value;
          pos <= IW'(req.position);
          rsp.read_data <= 8'd0;
          rsp.found <= 1'b0;
          rsp.error_code <= ERR_OK;
          sorting <= 1'b0;
        end
        S_WALK: begin
          case (act)
            ACT_ADD_REAR: if (full) begin
              if (front > 0) begin
                // move the entries from front+1 down to slot 0
                cmd.start <= 1'b1; cmd.op <= WALK_COPY;
                a_init <= '0; b_init <= front + 2'sd1;
              end else rsp.error_code <= ERR_FULL;
            end
            ACT_ADD_FRONT: if (full) rsp.error_code <= ERR_FULL;
              else if (!empty && front < 0) begin
                cmd.start <= 1'b1; cmd.op <= WALK_UP;
                a_init <= rear; b_init <= '0;
              end
            ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR, ACT_REPLACE:
              if (empty) rsp.error_code <= ERR_EMPTY;
            ACT_MEMBER: if (n > 0) begin
              cmd.start <= 1'b1; cmd.op <= WALK_SCAN;
              a_init <= front + 2'sd1; b_init <= rear;
            end
            ACT_REVERSE: if (n > 1) begin
              cmd.start <= 1'b1; cmd.op <= WALK_SWAP;
              a_init <= front + 2'sd1; b_init <= rear;
            end
            ACT_GET: if (pos >= n) rsp.error_code <= ERR_POS;
            ACT_REMOVE: if (pos >= n) rsp.error_code <= ERR_POS;
              else begin
                cmd.start <= 1'b1; cmd.op <= WALK_DOWN;
                a_init <= front + 2'sd1 + pos; b_init <= rear;
              end
            ACT_INSERT: if (full) rsp.error_code <= ERR_FULL;
              else if (pos > n) rsp.error_code <= ERR_POS;
              else if (!empty && pos < n) begin
                cmd.start <= 1'b1; cmd.op <= WALK_UP;
                a_init <= rear; b_init <= front + 2'sd1 + pos;
              end
            ACT_SORT: if (n > 1) begin
              cmd.start <= 1'b1; cmd.op <= WALK_CMP;
              a_init <= front + 2'sd1; b_init <= rear;
              sorting <= 1'b1;
              pass <= n - 2'sd1;
            end
            default: ;
          endcase
        end
        S_WAIT: if (!sts.busy && !cmd.start && sorting && pass > 1 && swapped) begin
          // next bubble pass, one shorter; stop early once nothing moved
          cmd.start <= 1'b1; cmd.op <= WALK_CMP;
          a_init <= front + 2'sd1;
          b_init <= rear - (n - pass);
          pass <= pass - 2'sd1;
        end
        S_FIN: begin
          if (rsp.error_code == ERR_OK) begin
            case (act)
              ACT_ADD_REAR: begin
                if (empty) begin front <= NEG1; rear <= '0; wr_addr <= '0; end
                else if (full) begin
                  // entries now sit in slots 0..n-1
                  front <= NEG1; rear <= n; wr_addr <= n;
                end else begin rear <= rear + 2'sd1; wr_addr <= rear + 2'sd1; end
                wr_en <= 1'b1; wr_data <= val;
              end
              ACT_ADD_FRONT: begin
                wr_en <= 1'b1; wr_data <= val;
                if (empty) begin front <= NEG1; rear <= '0; wr_addr <= '0; end
                else if (front < 0) begin rear <= rear + 2'sd1; wr_addr <= '0; end
                else begin wr_addr <= front; front <= front - 2'sd1; end
              end
              ACT_POP_FRONT: begin
                rsp.read_data <= rd_data;
                if (front + 2'sd1 == rear) begin front <= NEG1; rear <= NEG1; end
                else front <= front + 2'sd1;
              end
              ACT_POP_REAR: begin
                rsp.read_data <= rd_data;
                if (rear - 2'sd1 == front) begin front <= NEG1; rear <= NEG1; end
                else rear <= rear - 2'sd1;
              end
              ACT_PEEK_FRONT, ACT_PEEK_REAR, ACT_GET: rsp.read_data <= rd_data;
              ACT_MEMBER: rsp.found <= hit && (n > 0);
              ACT_REPLACE: begin wr_en <= 1'b1; wr_addr <= rear; wr_data <= val; end
              ACT_CLEAR: begin front <= NEG1; rear <= NEG1; end
              ACT_REMOVE: begin
                if (rear - 2'sd1 == front) begin front <= NEG1; rear <= NEG1; end
                else rear <= rear - 2'sd1;
              end
              ACT_INSERT: begin
                wr_en <= 1'b1; wr_data <= val;
                if (empty) begin front <= NEG1; rear <= '0; wr_addr <= '0; end
                else begin wr_addr <= front + 2'sd1 + pos; rear <= rear + 2'sd1; end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (act)
      ACT_POP_FRONT, ACT_PEEK_FRONT: rd_addr = front + 2'sd1;
      ACT_GET: rd_addr = front + 2'sd1 + pos;
      default: rd_addr = rear;
    endcase
  end

  assign rsp.entry_count = 5'(n);
  assign rsp.is_full     = full;
  assign rsp.vacant      = empty;
  assign rsp.front_place = 5'(front + 3'sd2);
  assign rsp.rear_place  = 5'(rear + 2'sd1);

  ap_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
  ap_excl: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("accept while result pending");
  ap_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) && sts.busy |=> state == S_WAIT) else $error("left walk early");
endmodule

@@ rtl/core/array_deque_engine.sv @@
// array_deque_engine: top level of the byte deque engine.
// Depends on ade_pkg, ade_if, ade_store, ade_ctrl.
//
//  channel | dir | handshake     | beat payload
//  req     | in  | valid/ready   | action, value, position
//  rsp     | out | valid/ready   | read_data, found, error_code, counts, places
//
// One request at a time: from accept it passes S_WALK, S_WAIT, S_FIN and S_OUT
// before the next accept. A walk over m steps (up to DEPTH) holds it in S_WAIT;
// sort chains up to DEPTH-2 further passes, stopping after a clean pass.
// Reset (rst, synchronous) sets both indices to -1; the store is not cleared.
// A stalled result holds in its register; no request is taken until it leaves.
module array_deque_engine import ade_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  ade_req_if.sink   req,
  ade_rsp_if.source rsp
);
  // signed index width: room for position (5 bits) added to an index
  localparam int IW = (($clog2(DEPTH) > 5) ? $clog2(DEPTH) : 5) + 2;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [IW-1:0] a_init, b_init, wr_addr, rd_addr;
  logic [7:0] value, wr_data, rd_data;
  logic wr_en, hit, swapped;

  ade_ctrl #(.DEPTH(DEPTH), .IW(IW)) u_ctrl (
    .clk, .rst, .req, .rsp, .cmd, .a_init, .b_init, .value, .wr_en, .wr_addr,
    .wr_data, .rd_addr, .rd_data, .hit, .swapped, .sts);

  ade_store #(.DEPTH(DEPTH), .IW(IW)) u_store (
    .clk, .rst, .cmd, .a_init, .b_init, .value, .wr_en, .wr_addr, .wr_data,
    .rd_addr, .rd_data, .hit, .swapped, .sts);
endmodule

@@ test/testbench.sv @@
// testbench: self-checking bench for array_deque_engine.
// Depends on ade_pkg, ade_if and the engine RTL; the expected beats come from
// an in-bench model of the deque, or for typed directed rows from the row itself.
`timescale 1ns / 1ps

module testbench;
  import ade_pkg::*;

  localparam int DEPTH = 16;
  localparam int N_RANDOM = 1500;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [7:0] read_data;
    logic       found;
    logic [2:0] error_code;
    logic [4:0] entry_count;
    logic       is_full;
    logic       vacant;
    logic [4:0] front_place;
    logic [4:0] rear_place;
  } status_t;

  typedef struct {
    action_t    act;
    logic [7:0] val;
    logic [4:0] pos;
    bit         typed;
    status_t    want;
  } step_t;

  logic clk;
  logic rst;
  ade_req_if req ();
  ade_rsp_if rsp ();

  array_deque_engine #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Model of the deque: store, front one slot before the first entry, rear at the last.
  logic [7:0] slots[DEPTH];
  int         head_idx;
  int         tail_idx;
  status_t    pending[$];
  bit         failed;
  bit         hold_rsp;   // asks the receiver for one long hold-off
  bit         calm;       // stretch with no idling on either side
  int         n_seen;

  function automatic logic [7:0] slot_rd(int i);
    if (i < 0 || i >= DEPTH) return 8'd0;
    return slots[i];
  endfunction

  function automatic void slot_wr(int i, logic [7:0] v);
    if (i >= 0 && i < DEPTH) slots[i] = v;
  endfunction

  function automatic int deque_len();
    if (head_idx == tail_idx || tail_idx < head_idx) return 0;
    return tail_idx - head_idx;
  endfunction

  function automatic status_t deque_step(action_t act, logic [7:0] val, logic [4:0] pos_in);
    status_t    s;
    logic [7:0] t;
    int         n;
    int         p;
    int         a;
    int         b;
    s = '0;
    n = deque_len();
    p = pos_in;
    case (act)
      ACT_ADD_REAR: begin
        if (tail_idx == DEPTH - 1) begin
          if (head_idx > 0) begin
            // compact to the bottom, then push
            for (int i = 0; i < n; i++) slot_wr(i, slot_rd(head_idx + 1 + i));
            tail_idx = n - 1;
            head_idx = -1;
          end else begin
            s.error_code = ERR_FULL;
          end
        end
        if (s.error_code == ERR_OK) begin
          if (head_idx == tail_idx) begin
            head_idx = -1;
            tail_idx = 0;
          end else begin
            tail_idx++;
          end
          slot_wr(tail_idx, val);
        end
      end
      ACT_ADD_FRONT: begin
        if (tail_idx == DEPTH - 1) begin
          s.error_code = ERR_FULL;
        end else if (head_idx == tail_idx) begin
          head_idx = -1;
          tail_idx = 0;
          slot_wr(0, val);
        end else if (head_idx < 0) begin
          if (tail_idx >= DEPTH - 1) begin
            s.error_code = ERR_SHIFT;
          end else begin
            for (int i = tail_idx; i >= 0; i--) slot_wr(i + 1, slot_rd(i));
            tail_idx++;
            slot_wr(0, val);
          end
        end else begin
          slot_wr(head_idx, val);
          head_idx--;
        end
      end
      ACT_POP_FRONT: begin
        if (head_idx == tail_idx) begin
          s.error_code = ERR_EMPTY;
        end else begin
          head_idx++;
          s.read_data = slot_rd(head_idx);
          if (head_idx == tail_idx) begin
            head_idx = -1;
            tail_idx = -1;
          end
        end
      end
      ACT_POP_REAR: begin
        if (head_idx == tail_idx) begin
          s.error_code = ERR_EMPTY;
        end else begin
          s.read_data = slot_rd(tail_idx);
          tail_idx--;
          if (head_idx == tail_idx) begin
            head_idx = -1;
            tail_idx = -1;
          end
        end
      end
      ACT_PEEK_FRONT: begin
        if (head_idx == tail_idx) s.error_code = ERR_EMPTY;
        else s.read_data = slot_rd(head_idx + 1);
      end
      ACT_PEEK_REAR: begin
        if (head_idx == tail_idx) s.error_code = ERR_EMPTY;
        else s.read_data = slot_rd(tail_idx);
      end
      ACT_MEMBER: begin
        for (int i = 0; i < n; i++)
          if (slot_rd(head_idx + 1 + i) == val) s.found = 1'b1;
      end
      ACT_REPLACE: begin
        if (head_idx == tail_idx) s.error_code = ERR_EMPTY;
        else slot_wr(tail_idx, val);
      end
      ACT_CLEAR: begin
        head_idx = -1;
        tail_idx = -1;
      end
      ACT_REVERSE: begin
        a = head_idx + 1;
        b = tail_idx;
        while (n > 1 && a < b) begin
          t = slot_rd(a);
          slot_wr(a, slot_rd(b));
          slot_wr(b, t);
          a++;
          b--;
        end
      end
      ACT_GET: begin
        if (p >= n) s.error_code = ERR_POS;
        else s.read_data = slot_rd(head_idx + 1 + p);
      end
      ACT_REMOVE: begin
        if (p >= n) begin
          s.error_code = ERR_POS;
        end else begin
          for (int i = head_idx + 1 + p; i < tail_idx; i++) slot_wr(i, slot_rd(i + 1));
          tail_idx--;
          if (head_idx == tail_idx) begin
            head_idx = -1;
            tail_idx = -1;
          end
        end
      end
      ACT_INSERT: begin
        if (tail_idx == DEPTH - 1) begin
          s.error_code = ERR_FULL;
        end else if (p > n) begin
          s.error_code = ERR_POS;
        end else if (head_idx == tail_idx) begin
          head_idx = -1;
          tail_idx = 0;
          slot_wr(0, val);
        end else begin
          for (int i = tail_idx; i >= head_idx + 1 + p; i--) slot_wr(i + 1, slot_rd(i));
          slot_wr(head_idx + 1 + p, val);
          tail_idx++;
        end
      end
      ACT_SORT: begin
        for (int i = 0; i + 1 < n; i++)
          for (int k = head_idx + 1; k < head_idx + n - i; k++)
            if (slot_rd(k) > slot_rd(k + 1)) begin
              t = slot_rd(k);
              slot_wr(k, slot_rd(k + 1));
              slot_wr(k + 1, t);
            end
      end
      default: ;
    endcase
    if (s.error_code != ERR_OK) begin
      s.read_data = 8'd0;
      s.found = 1'b0;
    end
    s.entry_count = 5'(deque_len());
    s.is_full     = (tail_idx == DEPTH - 1);
    s.vacant      = (head_idx == tail_idx);
    s.front_place = 5'(head_idx + 2);
    s.rear_place  = 5'(tail_idx + 1);
    return s;
  endfunction

  function automatic status_t mk(logic [7:0] d, logic f, logic [2:0] e, logic [4:0] c,
                                 logic fu, logic em, logic [4:0] fp, logic [4:0] rp);
    status_t s;
    s = '{d, f, e, c, fu, em, fp, rp};
    return s;
  endfunction

  function automatic step_t row(action_t a, logic [7:0] v, logic [4:0] p);
    step_t r;
    r = '{a, v, p, 1'b0, '0};
    return r;
  endfunction

  function automatic step_t trow(action_t a, logic [7:0] v, logic [4:0] p, status_t w);
    step_t r;
    r = '{a, v, p, 1'b1, w};
    return r;
  endfunction

  // Directed rows: empty-deque errors, unused actions, shift at front, bad insert
  // position, then every remaining action on a small deque.
  step_t directed[$];

  initial begin
    directed = '{
      trow(ACT_PEEK_FRONT, 8'h00, 5'd0, mk(0, 0, ERR_EMPTY, 0, 0, 1, 1, 0)),
      trow(ACT_POP_REAR,   8'h00, 5'd0, mk(0, 0, ERR_EMPTY, 0, 0, 1, 1, 0)),
      trow(ACT_POP_FRONT,  8'hFF, 5'd0, mk(0, 0, ERR_EMPTY, 0, 0, 1, 1, 0)),
      trow(ACT_GET,        8'h00, 5'd0, mk(0, 0, ERR_POS, 0, 0, 1, 1, 0)),
      trow(ACT_REMOVE,     8'h00, 5'd16, mk(0, 0, ERR_POS, 0, 0, 1, 1, 0)),
      trow(ACT_REPLACE,    8'hFF, 5'd0, mk(0, 0, ERR_EMPTY, 0, 0, 1, 1, 0)),
      trow(ACT_PEEK_REAR,  8'h00, 5'd0, mk(0, 0, ERR_EMPTY, 0, 0, 1, 1, 0)),
      trow(ACT_MEMBER,     8'h00, 5'd0, mk(0, 0, ERR_OK, 0, 0, 1, 1, 0)),
      trow(ACT_REVERSE,    8'h00, 5'd0, mk(0, 0, ERR_OK, 0, 0, 1, 1, 0)),
      trow(ACT_SORT,       8'h00, 5'd0, mk(0, 0, ERR_OK, 0, 0, 1, 1, 0)),
      trow(ACT_NOP14,      8'hFF, 5'd31, mk(0, 0, ERR_OK, 0, 0, 1, 1, 0)),
      trow(ACT_NOP15,      8'hAA, 5'd15, mk(0, 0, ERR_OK, 0, 0, 1, 1, 0)),
      trow(ACT_CLEAR,      8'h00, 5'd0, mk(0, 0, ERR_OK, 0, 0, 1, 1, 0)),
      trow(ACT_ADD_REAR,   8'hFF, 5'd0, mk(0, 0, ERR_OK, 1, 0, 0, 1, 1)),
      trow(ACT_ADD_FRONT,  8'h00, 5'd0, mk(0, 0, ERR_OK, 2, 0, 0, 1, 2)),
      trow(ACT_INSERT,     8'h05, 5'd3, mk(0, 0, ERR_POS, 2, 0, 0, 1, 2)),
      row(ACT_INSERT,      8'h80, 5'd1),
      row(ACT_MEMBER,      8'h80, 5'd0),
      row(ACT_GET,         8'h00, 5'd2),
      row(ACT_REVERSE,     8'h00, 5'd0),
      row(ACT_SORT,        8'h00, 5'd0),
      row(ACT_REPLACE,     8'h7F, 5'd0),
      row(ACT_REMOVE,      8'h00, 5'd1),
      row(ACT_POP_FRONT,   8'h00, 5'd0),
      row(ACT_POP_REAR,    8'h00, 5'd0)
    };
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("array_deque_engine test failed");
    $finish;
  end

  // Random item: fill-heavy and drain-heavy episodes keep the deque moving
  // between empty and full, so compaction and the full-front cases come up.
  task automatic pick_item(input int k, output action_t a, output logic [7:0] v,
                           output logic [4:0] p);
    int n;
    int r;
    bit filling;
    n = deque_len();
    filling = ((k / 60) % 2) == 0;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      a = action_t'($urandom_range(0, 15));   // noise
    end else if (filling && r < 55) begin
      a = ($urandom_range(0, 2) == 0) ? ACT_ADD_FRONT :
          ($urandom_range(0, 1) ? ACT_ADD_REAR : ACT_INSERT);
    end else if (!filling && r < 45) begin
      a = ($urandom_range(0, 1)) ? ACT_POP_FRONT :
          ($urandom_range(0, 1) ? ACT_POP_REAR : ACT_REMOVE);
    end else if (r < 62) begin
      a = ACT_POP_FRONT;                       // opens room at the front
    end else begin
      a = action_t'($urandom_range(2, 13));
      if (a == ACT_CLEAR && $urandom_range(0, 3) != 0) a = ACT_MEMBER;
    end
    v = 8'($urandom());
    if (a == ACT_MEMBER && n > 0 && $urandom_range(0, 1))
      v = slot_rd(head_idx + 1 + $urandom_range(0, n - 1));
    if ($urandom_range(0, 7) == 0) p = 5'($urandom_range(0, 16));
    else p = 5'($urandom_range(0, n + 1));
  endtask

  // Sender: one beat per item, random gaps, one long pause until drained.
  initial begin
    action_t    a;
    logic [7:0] v;
    logic [4:0] p;
    int         gap;
    status_t    s;
    int         total;
    failed   = 1'b0;
    hold_rsp = 1'b0;
    calm     = 1'b0;
    head_idx = -1;
    tail_idx = -1;
    for (int i = 0; i < DEPTH; i++) slots[i] = 8'd0;
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.action <= '0;
    req.value <= '0;
    req.position <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    total = directed.size() + N_RANDOM;
    for (int k = 0; k < total; k++) begin
      if (k < directed.size()) begin
        a = directed[k].act;
        v = directed[k].val;
        p = directed[k].pos;
      end else begin
        pick_item(k, a, v, p);
      end
      if (k == 300) hold_rsp = 1'b1;
      calm = (k >= 900 && k < 1000);
      gap = calm ? 0 : $urandom_range(0, 12);
      if (k == 700) begin
        // drain fully before going on
        req.valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        gap = 1;
      end else if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end
      if (gap > 0) @(posedge clk);
      req.valid    <= 1'b1;
      req.action   <= a;
      req.value    <= v;
      req.position <= p;
      do @(posedge clk); while (!req.ready);
      s = deque_step(a, v, p);
      if (k < directed.size() && directed[k].typed) pending.push_back(directed[k].want);
      else pending.push_back(s);
    end
    req.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DEPTH * DEPTH + 50) @(posedge clk);
    if (!failed) begin
      $display("array_deque_engine test passed");
    end else begin
      $display("array_deque_engine test failed");
    end
    $finish;
  end

  task automatic compare_beat();
    status_t got;
    status_t want;
    got = '{rsp.read_data, rsp.found, rsp.error_code, rsp.entry_count, rsp.is_full,
            rsp.vacant, rsp.front_place, rsp.rear_place};
    n_seen++;
    if (pending.size() == 0) begin
      $display("%0t: result beat with nothing expected, got %p", $time, got);
      failed = 1'b1;
    end else begin
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: beat %0d mismatch, expected %p, actual %p", $time, n_seen, want, got);
        failed = 1'b1;
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold so requests back up.
  initial begin
    int stall;
    n_seen = 0;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      compare_beat();
    end
  end

endmodule
